// ===== rtl/esc_pkg.sv =====
// esc_pkg: payload types and fixed calendar constants for the epoch-seconds
// to calendar converter. No dependencies; compile first.
package esc_pkg;

    typedef struct packed {
        logic [31:0] epoch_seconds;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [11:0] year;
        logic [2:0]  weekday;
        logic [31:0] fat_stamp;
        logic        fat_in_range;
    } t_out_item;

    // day count shift to 0000-03-01 and era lengths
    localparam logic [19:0] DAYS_SHIFT  = 20'd719468;
    localparam logic [19:0] ERA4_START  = 20'd584388;   // 4 * 146097
    localparam logic [19:0] ERA5_START  = 20'd730485;   // 5 * 146097
    localparam logic [17:0] ERA_LAST    = 18'd146096;
    localparam logic [17:0] CENT_DAYS   = 18'd36524;
    localparam logic [11:0] FAT_YEAR0   = 12'd1980;
    localparam logic [11:0] FAT_YEAR1   = 12'd2107;
    localparam logic [11:0] ERA4_YEAR   = 12'd1600;
    localparam logic [11:0] ERA5_YEAR   = 12'd2000;

    // first day of each month in a march-based year, indexed by month from march
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

endpackage

// ===== rtl/esc_if.sv =====
// esc_if: valid/ready channel interfaces for input beats and result beats.
// Depends on esc_pkg for the payload types.
interface esc_in_if;
    import esc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface esc_out_if;
    import esc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/epoch_seconds_to_calendar_fat_top.sv =====
// Epoch seconds to calendar fields and FAT timestamp, seven register stages.
// A result is valid once its input beat has passed stage registers r0 to r5 and the output register.
// Throughput: one beat per cycle while the output is not stalled; each stage holds at most three short
// constant multiplies, and per-stage ready lets a stage fill while later ones stall.
// Reset (synchronous, active low) clears only the stage valid bits; no beat is taken in reset.
// Depends on esc_pkg and esc_if.
module epoch_seconds_to_calendar_fat_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    esc_in_if.sink        i_sec,
    esc_out_if.source     o_cal
);
    import esc_pkg::*;

    // reciprocals: floor(x/d) = (x*m) >> k with m = ceil(2^k/d)
    localparam logic [25:0] DAY_M   = 26'(((64'd1 << 35) + 64'd674) / 64'd675);
    localparam logic [16:0] WD_M    = 17'(((64'd1 << 19) + 64'd6) / 64'd7);
    localparam logic [13:0] HR_M    = 14'(((64'd1 << 21) + 64'd224) / 64'd225);
    localparam logic [16:0] Q1460_M = 17'(((64'd1 << 25) + 64'd364) / 64'd365);
    localparam logic [18:0] Y365_M  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [10:0] MIN_M   = 11'(((64'd1 << 14) + 64'd14) / 64'd15);
    localparam logic [9:0]  C100_M  = 10'(((64'd1 << 16) + 64'd99) / 64'd100);

    logic [6:0] r_v;
    logic [6:0] w_en;

    // stage registers
    logic [31:0] r0_t;
    logic [31:0] r1_t;
    logic [15:0] r1_days;
    logic [16:0] r2_sod;
    logic        r2_era5;
    logic [17:0] r2_doe;
    logic [15:0] r2_w4;
    logic [13:0] r2_wq;
    logic [16:0] r3_sod;
    logic [4:0]  r3_hr;
    logic [17:0] r3_a;
    logic [17:0] r3_doe;
    logic        r3_era5;
    logic [2:0]  r3_wd;
    logic [11:0] r4_ms;
    logic [8:0]  r4_yoe;
    logic [17:0] r4_doe;
    logic        r4_era5;
    logic [4:0]  r4_hr;
    logic [2:0]  r4_wd;
    logic [11:0] r5_ms;
    logic [5:0]  r5_min;
    logic [8:0]  r5_doy;
    logic [8:0]  r5_yoe;
    logic        r5_era5;
    logic [4:0]  r5_hr;
    logic [2:0]  r5_wd;
    t_out_item   r_out;

    // next values
    logic [15:0] n1_days;
    logic [16:0] n2_sod;
    logic        n2_era5;
    logic [17:0] n2_doe;
    logic [15:0] n2_w4;
    logic [13:0] n2_wq;
    logic [4:0]  n3_hr;
    logic [17:0] n3_a;
    logic [2:0]  n3_wd;
    logic [11:0] n4_ms;
    logic [8:0]  n4_yoe;
    logic [5:0]  n5_min;
    logic [8:0]  n5_doy;
    t_out_item   n_out;

    // handshake: a stage loads when empty or when the next one loads
    always_comb begin
        w_en[6] = !r_v[6] || o_cal.ready;
        for (int k = 5; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_sec.ready = w_en[0] && i_rst_n;
    assign o_cal.valid = r_v[6];
    assign o_cal.data  = r_out;

    // stage 1: day count
    logic [50:0] w_pday;
    assign w_pday  = 51'(r0_t[31:7]) * 51'(DAY_M);
    assign n1_days = w_pday[50:35];

    // stage 2: second of day, day of era, weekday quotient
    logic [31:0] w_sod;
    logic [19:0] w_z;
    logic [19:0] w_doe;
    logic [32:0] w_pwd;
    always_comb begin
        w_sod   = r1_t - 32'(r1_days) * 32'd86400;
        n2_sod  = w_sod[16:0];
        w_z     = 20'(r1_days) + DAYS_SHIFT;
        n2_era5 = (w_z >= ERA5_START);
        w_doe   = n2_era5 ? (w_z - ERA5_START) : (w_z - ERA4_START);
        n2_doe  = w_doe[17:0];
        n2_w4   = r1_days + 16'd4;
        w_pwd   = 33'(n2_w4) * 33'(WD_M);
        n2_wq   = w_pwd[32:19];
    end

    // stage 3: hour, leap-corrected day of era, weekday
    logic [26:0] w_phr;
    logic [32:0] w_p1460;
    logic [2:0]  w_cent;
    logic [15:0] w_wd;
    always_comb begin
        w_phr   = 27'(r2_sod[16:4]) * 27'(HR_M);
        n3_hr   = w_phr[25:21];
        w_p1460 = 33'(r2_doe[17:2]) * 33'(Q1460_M);
        w_cent  = 3'(r2_doe >= CENT_DAYS) + 3'(r2_doe >= 18'(2 * CENT_DAYS))
                + 3'(r2_doe >= 18'(3 * CENT_DAYS)) + 3'(r2_doe >= ERA_LAST);
        n3_a    = r2_doe - 18'(w_p1460[32:25]) + 18'(w_cent)
                - 18'(r2_doe == ERA_LAST);
        w_wd    = r2_w4 - 16'(r2_wq) * 16'd7;
        n3_wd   = w_wd[2:0];
    end

    // stage 4: seconds within hour, year of era
    logic [16:0] w_ms;
    logic [36:0] w_py;
    always_comb begin
        w_ms   = r3_sod - 17'(r3_hr) * 17'd3600;
        n4_ms  = w_ms[11:0];
        w_py   = 37'(r3_a) * 37'(Y365_M);
        n4_yoe = w_py[35:27];
    end

    // stage 5: minute, day of year
    logic [20:0] w_pmin;
    logic [18:0] w_p100;
    logic [17:0] w_doy;
    always_comb begin
        w_pmin = 21'(r4_ms[11:2]) * 21'(MIN_M);
        n5_min = w_pmin[19:14];
        w_p100 = 19'(r4_yoe) * 19'(C100_M);
        w_doy  = r4_doe - (18'(r4_yoe) * 18'd365 + 18'(r4_yoe[8:2])
               - 18'(w_p100[17:16]));
        n5_doy = w_doy[8:0];
    end

    // stage 6: month, day, year and fat packing
    logic [11:0] w_sec;
    logic [3:0]  w_mp;
    logic [8:0]  w_dd;
    logic [3:0]  w_mon;
    logic [11:0] w_year;
    logic [11:0] w_fy;
    always_comb begin
        w_sec = r5_ms - 12'(r5_min) * 12'd60;
        w_mp  = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (r5_doy >= MONTH_START[k]) begin
                w_mp = 4'(k);
            end
        end
        w_dd   = r5_doy - MONTH_START[w_mp] + 9'd1;
        w_mon  = (w_mp < 4'd10) ? (w_mp + 4'd3) : (w_mp - 4'd9);
        w_year = 12'(r5_yoe) + (r5_era5 ? ERA5_YEAR : ERA4_YEAR)
               + 12'(w_mon <= 4'd2);
        w_fy   = w_year - FAT_YEAR0;

        n_out.second       = w_sec[5:0];
        n_out.minute       = r5_min;
        n_out.hour         = r5_hr;
        n_out.day_of_month = w_dd[4:0];
        n_out.month        = w_mon;
        n_out.year         = w_year;
        n_out.weekday      = r5_wd;
        n_out.fat_stamp    = {w_fy[6:0], w_mon, w_dd[4:0], r5_hr, r5_min, w_sec[5:1]};
        n_out.fat_in_range = (w_year >= FAT_YEAR0) && (w_year <= FAT_YEAR1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_sec.valid;
            end
            for (int k = 1; k < 7; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_t <= i_sec.data.epoch_seconds;
        end
        if (w_en[1]) begin
            r1_t    <= r0_t;
            r1_days <= n1_days;
        end
        if (w_en[2]) begin
            r2_sod  <= n2_sod;
            r2_era5 <= n2_era5;
            r2_doe  <= n2_doe;
            r2_w4   <= n2_w4;
            r2_wq   <= n2_wq;
        end
        if (w_en[3]) begin
            r3_sod  <= r2_sod;
            r3_hr   <= n3_hr;
            r3_a    <= n3_a;
            r3_doe  <= r2_doe;
            r3_era5 <= r2_era5;
            r3_wd   <= n3_wd;
        end
        if (w_en[4]) begin
            r4_ms   <= n4_ms;
            r4_yoe  <= n4_yoe;
            r4_doe  <= r3_doe;
            r4_era5 <= r3_era5;
            r4_hr   <= r3_hr;
            r4_wd   <= r3_wd;
        end
        if (w_en[5]) begin
            r5_ms   <= r4_ms;
            r5_min  <= n5_min;
            r5_doy  <= n5_doy;
            r5_yoe  <= r4_yoe;
            r5_era5 <= r4_era5;
            r5_hr   <= r4_hr;
            r5_wd   <= r4_wd;
        end
        if (w_en[6]) begin
            r_out <= n_out;
        end
    end

    // input stalls only when every stage holds a beat
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_sec.ready |-> (&r_v))
        else $error("input stalled with an empty stage");

    // a stalled stage keeps its beat
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[5] && !w_en[5]) |=> (r_v[5] && $stable(r5_doy) && $stable(r5_ms)))
        else $error("stalled stage lost its contents");

    // fat range flag agrees with the year (year never exceeds 2107)
    a_range_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cal.valid |-> (o_cal.data.fat_in_range == (o_cal.data.year >= FAT_YEAR0)))
        else $error("fat range flag disagrees with year");

    // packed stamp carries the same day, month and halved second
    a_stamp_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cal.valid |-> (o_cal.data.fat_stamp[20:16] == o_cal.data.day_of_month
                         && o_cal.data.fat_stamp[4:0] == o_cal.data.second[5:1]
                         && o_cal.data.fat_stamp[24:21] == o_cal.data.month))
        else $error("fat stamp fields disagree with calendar fields");

endmodule
